### rtl/ramst_pkg.sv
// shared types, widths and helpers for the range-add max tree
package ramst_pkg;

    localparam int unsigned PosW = 11;
    localparam int unsigned DeltaW = 32;
    localparam int unsigned ValW = 64;

    typedef logic [PosW-1:0] t_pos;
    typedef logic signed [ValW-1:0] t_val;

    function automatic t_val smax(input t_val a, input t_val b);
        smax = (a > b) ? a : b;
    endfunction

endpackage

### rtl/ramst_mem.sv
// node store: maximum and pending add per node, registered read with data in the next cycle
module ramst_mem #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW = 12
) (
    input  logic                 i_clk,
    input  logic [AW-1:0]        i_rd_addr,
    output ramst_pkg::t_val      o_rd_max,
    output ramst_pkg::t_val      o_rd_pend,
    input  logic                 i_we_max,
    input  logic                 i_we_pend,
    input  logic [AW-1:0]        i_wr_addr,
    input  ramst_pkg::t_val      i_wr_max,
    input  ramst_pkg::t_val      i_wr_pend
);

    ramst_pkg::t_val r_max_mem [DEPTH];
    ramst_pkg::t_val r_pend_mem [DEPTH];
    ramst_pkg::t_val r_rd_max;
    ramst_pkg::t_val r_rd_pend;

    always_ff @(posedge i_clk) begin
        if (i_we_max) begin
            r_max_mem[i_wr_addr] <= i_wr_max;
        end
        if (i_we_pend) begin
            r_pend_mem[i_wr_addr] <= i_wr_pend;
        end
        r_rd_max <= r_max_mem[i_rd_addr];
        r_rd_pend <= r_pend_mem[i_rd_addr];
    end

    assign o_rd_max = r_rd_max;
    assign o_rd_pend = r_rd_pend;

endmodule

### rtl/range_add_max_segment_tree.sv
// top level: range-add / global-max segment tree walked over the node store
// an empty or outside range only reads the root maximum; others walk down from the root
// a covered node takes the add; a split node pushes its pending add down, then recurses
// throughput: one item at a time, busy stays high until o_done
// reset clears all 4*LEAVES_MAX node entries of the store, busy high meanwhile
// o_done marks a one-cycle result beat; the receiver cannot stall
module range_add_max_segment_tree #(
    parameter int unsigned LEAVES_MAX = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [10:0]            i_cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [10:0]            i_range_lo,
    input  logic [10:0]            i_range_hi,
    input  logic signed [31:0]     i_delta,
    output logic                   o_done,
    output logic signed [63:0]     o_global_max
);

    localparam int unsigned NodeCount = 4 * LEAVES_MAX;
    localparam int unsigned AW = $clog2(NodeCount);
    localparam int unsigned SD = AW;
    localparam int unsigned SIW = $clog2(SD);
    localparam int unsigned SPW = $clog2(SD + 1);
    localparam int unsigned CntRst = (LEAVES_MAX < 1024) ? LEAVES_MAX : 1024;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_EVAL, S_PL, S_PR,
        S_RET, S_NEXT, S_CL, S_CR, S_CW, S_ORD, S_OUT
    } t_state;

    typedef struct packed {
        logic [AW-1:0]    node;
        ramst_pkg::t_pos  from;
        ramst_pkg::t_pos  to;
        logic             phase;
    } t_frame;

    t_state            r_state;
    ramst_pkg::t_pos   r_cnt;
    ramst_pkg::t_pos   r_lo;
    ramst_pkg::t_pos   r_hi;
    ramst_pkg::t_val   r_amt;
    ramst_pkg::t_val   r_carry;
    ramst_pkg::t_val   r_lmax;
    logic [AW-1:0]     r_node;
    ramst_pkg::t_pos   r_from;
    ramst_pkg::t_pos   r_to;
    logic              r_phase;
    logic [SPW-1:0]    r_sp;
    t_frame            r_stack [SD];
    logic [AW-1:0]     r_clr;
    logic              r_done;
    ramst_pkg::t_val   r_gmax;

    logic [AW-1:0]     rd_addr;
    logic              we_max;
    logic              we_pend;
    logic [AW-1:0]     wr_addr;
    ramst_pkg::t_val   wr_max;
    ramst_pkg::t_val   wr_pend;
    ramst_pkg::t_val   rd_max;
    ramst_pkg::t_val   rd_pend;

    logic [AW-1:0]     left_node;
    logic [AW-1:0]     right_node;
    logic              no_child;
    logic [11:0]       pos_sum;
    ramst_pkg::t_pos   mid;
    ramst_pkg::t_pos   mid_p1;
    logic              full_cover;
    logic [SPW-1:0]    sp_m1;
    t_frame            top_frame;
    logic              range_ok;
    logic [10:0]       cfg_v;

    assign left_node = AW'({r_node, 1'b0});
    assign right_node = AW'({r_node, 1'b1});
    assign no_child = ({1'b0, r_node, 1'b1} >= (AW + 2)'(NodeCount));
    assign pos_sum = {1'b0, r_from} + {1'b0, r_to};
    assign mid = pos_sum[11:1];
    assign mid_p1 = mid + 11'd1;
    assign full_cover = (r_lo <= r_from) && (r_to <= r_hi);
    assign sp_m1 = r_sp - 1'b1;
    assign top_frame = r_stack[sp_m1[SIW-1:0]];
    assign range_ok = (i_range_lo != 11'd0) && (i_range_lo <= i_range_hi)
                   && (i_range_hi <= r_cnt);
    assign cfg_v = (i_cfg_data == 11'd0) ? 11'd1 :
                   ((32'(i_cfg_data) > 32'(LEAVES_MAX)) ? 11'(LEAVES_MAX) : i_cfg_data);

    // memory port steering per state
    always_comb begin
        rd_addr = r_node;
        we_max = 1'b0;
        we_pend = 1'b0;
        wr_addr = r_node;
        wr_max = '0;
        wr_pend = '0;
        case (r_state)
            S_CLEAR: begin
                we_max = 1'b1;
                we_pend = 1'b1;
                wr_addr = r_clr;
            end
            S_EVAL: begin
                if (full_cover) begin
                    we_max = 1'b1;
                    we_pend = 1'b1;
                    wr_max = rd_max + r_amt;
                    wr_pend = rd_pend + r_amt;
                end else if (!no_child) begin
                    we_pend = 1'b1;
                    rd_addr = left_node;
                end
            end
            S_PL: begin
                we_max = 1'b1;
                we_pend = 1'b1;
                wr_addr = left_node;
                wr_max = rd_max + r_carry;
                wr_pend = rd_pend + r_carry;
                rd_addr = right_node;
            end
            S_PR: begin
                we_max = 1'b1;
                we_pend = 1'b1;
                wr_addr = right_node;
                wr_max = rd_max + r_carry;
                wr_pend = rd_pend + r_carry;
            end
            S_CL: rd_addr = left_node;
            S_CR: rd_addr = right_node;
            S_CW: begin
                we_max = 1'b1;
                wr_max = ramst_pkg::smax(r_lmax, rd_max);
            end
            S_ORD: rd_addr = AW'(1);
            default: begin
                rd_addr = r_node;
            end
        endcase
    end

    ramst_mem #(
        .DEPTH (NodeCount),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_rd_max  (rd_max),
        .o_rd_pend (rd_pend),
        .i_we_max  (we_max),
        .i_we_pend (we_pend),
        .i_wr_addr (wr_addr),
        .i_wr_max  (wr_max),
        .i_wr_pend (wr_pend)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt <= 11'(CntRst);
            r_clr <= '0;
            r_sp <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_cnt <= cfg_v;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(NodeCount - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_lo <= i_range_lo;
                        r_hi <= i_range_hi;
                        r_amt <= ramst_pkg::t_val'(i_delta);
                        r_node <= AW'(1);
                        r_from <= 11'd1;
                        r_to <= r_cnt;
                        r_sp <= '0;
                        r_state <= range_ok ? S_RD : S_ORD;
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    r_carry <= rd_pend;
                    if (full_cover || no_child) begin
                        r_state <= S_RET;
                    end else begin
                        r_state <= S_PL;
                    end
                end
                S_PL: r_state <= S_PR;
                S_PR: begin
                    // descend left first when the range reaches it
                    r_stack[r_sp[SIW-1:0]] <= '{node: r_node, from: r_from, to: r_to,
                                               phase: (r_lo > mid)};
                    r_sp <= r_sp + 1'b1;
                    if (r_lo <= mid) begin
                        r_node <= left_node;
                        r_to <= mid;
                    end else begin
                        r_node <= right_node;
                        r_from <= mid_p1;
                    end
                    r_state <= S_RD;
                end
                S_RET: begin
                    if (r_sp == '0) begin
                        r_state <= S_ORD;
                    end else begin
                        r_node <= top_frame.node;
                        r_from <= top_frame.from;
                        r_to <= top_frame.to;
                        r_phase <= top_frame.phase;
                        r_sp <= sp_m1;
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (!r_phase && (mid < r_hi)) begin
                        r_stack[r_sp[SIW-1:0]] <= '{node: r_node, from: r_from, to: r_to,
                                                   phase: 1'b1};
                        r_sp <= r_sp + 1'b1;
                        r_node <= right_node;
                        r_from <= mid_p1;
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_CL;
                    end
                end
                S_CL: r_state <= S_CR;
                S_CR: begin
                    r_lmax <= rd_max;
                    r_state <= S_CW;
                end
                S_CW: r_state <= S_RET;
                S_ORD: r_state <= S_OUT;
                S_OUT: begin
                    r_gmax <= rd_max;
                    r_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_global_max = r_gmax;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without a walk");
    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(SD))
        else $error("walk stack overflow");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result beat repeated");
`endif

endmodule

### dv/tb_range_add_max_segment_tree.sv
// testbench for the range-add / global-max segment tree: tree predictor, driver and monitor
module tb_range_add_max_segment_tree;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEAVES = 1024;
    localparam int unsigned NODES = 4 * LEAVES;
    localparam int unsigned SETTLE = 300;

    typedef enum logic [1:0] {K_ADD, K_CFG, K_DRAIN} t_kind;
    typedef struct packed {
        t_kind             kind;
        ramst_pkg::t_pos   lo;
        ramst_pkg::t_pos   hi;
        logic signed [31:0] delta;
        logic [10:0]       count;
    } t_beat;

    logic i_clk, i_rst_n, i_cfg_we, start, busy, o_done;
    logic [10:0] i_cfg_data, i_range_lo, i_range_hi;
    logic signed [31:0] i_delta;
    logic signed [63:0] o_global_max;

    range_add_max_segment_tree #(.LEAVES_MAX(LEAVES)) dut (.*);

    // predictor state
    logic [63:0] span_max[NODES];
    logic [63:0] span_tag[NODES];
    int unsigned leaf_cnt;

    t_beat pending_q[$];
    logic signed [63:0] max_q[$];
    int unsigned n_sent, n_taken, n_seen, n_err, n_cfg, n_bad_range, quiet;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        n_err++;
    endtask

    function automatic void tag_span(input int unsigned node, input logic [63:0] amt);
        if (node >= NODES) return;
        span_max[node] += amt;
        span_tag[node] += amt;
    endfunction

    function automatic void add_range(input int unsigned lo, input int unsigned hi,
                                      input int unsigned node, input int unsigned from,
                                      input int unsigned to, input logic [63:0] amt);
        int unsigned l, r, mid;
        if (node >= NODES) return;
        if (lo <= from && to <= hi) begin
            tag_span(node, amt);
            return;
        end
        l = 2 * node;
        r = l + 1;
        if (r >= NODES) return;
        tag_span(l, span_tag[node]);
        tag_span(r, span_tag[node]);
        span_tag[node] = '0;
        mid = (from + to) >> 1;
        if (lo <= mid) add_range(lo, (hi < mid) ? hi : mid, l, from, mid, amt);
        if (mid < hi) add_range((lo > mid + 1) ? lo : mid + 1, hi, r, mid + 1, to, amt);
        span_max[node] = ($signed(span_max[l]) > $signed(span_max[r])) ? span_max[l]
                                                                        : span_max[r];
    endfunction

    function automatic void predict_add(input int unsigned lo, input int unsigned hi,
                                        input logic signed [31:0] d);
        logic [63:0] amt;
        amt = {{32{d[31]}}, d};
        if (lo >= 1 && lo <= hi && hi <= leaf_cnt) add_range(lo, hi, 1, 1, leaf_cnt, amt);
        else n_bad_range++;
        max_q.push_back($signed(span_max[1]));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // accept side and result check
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                leaf_cnt = (i_cfg_data == 0) ? 1 : (i_cfg_data > LEAVES) ? LEAVES : i_cfg_data;
                n_cfg++;
            end
            if (start && !busy) begin
                predict_add(i_range_lo, i_range_hi, i_delta);
                n_taken++;
            end
            if (o_done) begin
                n_seen++;
                if (max_q.size() == 0) report("result beat with nothing expected");
                else begin
                    if (o_global_max !== max_q[0])
                        report($sformatf("global_max %0d, want %0d", o_global_max, max_q[0]));
                    void'(max_q.pop_front());
                end
            end
            if (o_done || max_q.size() != 0 || start || busy) quiet = 0;
            else quiet++;
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_beat b;
        logic nxt_start, nxt_we;
        int unsigned pct;
        nxt_start = 1'b0;
        nxt_we = 1'b0;
        if (!i_rst_n) begin
            nxt_start = 1'b0;
        end else if (start && n_taken < n_sent) begin
            nxt_start = 1'b1;
        end else if (pending_q.size() != 0) begin
            b = pending_q[0];
            pct = (n_sent < 370) ? 18 : (n_sent < 740) ? 53 : 0;
            case (b.kind)
                K_ADD: begin
                    if ($urandom_range(99) >= pct) begin
                        i_range_lo <= b.lo;
                        i_range_hi <= b.hi;
                        i_delta <= b.delta;
                        nxt_start = 1'b1;
                        n_sent++;
                        void'(pending_q.pop_front());
                    end
                end
                K_CFG: begin
                    if (quiet >= SETTLE && !i_cfg_we) begin
                        i_cfg_data <= b.count;
                        nxt_we = 1'b1;
                        void'(pending_q.pop_front());
                    end
                end
                default: begin
                    if (quiet >= 2) void'(pending_q.pop_front());
                end
            endcase
        end
        start <= nxt_start;
        i_cfg_we <= nxt_we;
    end

    task automatic push_add(input int unsigned lo, input int unsigned hi,
                            input logic signed [31:0] d);
        t_beat b;
        b = '0;
        b.kind = K_ADD;
        b.lo = ramst_pkg::t_pos'(lo);
        b.hi = ramst_pkg::t_pos'(hi);
        b.delta = d;
        pending_q.push_back(b);
    endtask

    task automatic push_kind(input t_kind k, input logic [10:0] c);
        t_beat b;
        b = '0;
        b.kind = k;
        b.count = c;
        pending_q.push_back(b);
    endtask

    task automatic push_random(input int unsigned n, input int unsigned cnt);
        int unsigned lo, hi;
        logic signed [31:0] d;
        repeat (n) begin
            if ($urandom_range(99) < 12) begin
                lo = $urandom_range(2047);
                hi = $urandom_range(2047);
            end else begin
                lo = $urandom_range(cnt, 1);
                hi = $urandom_range(cnt, lo);
            end
            d = ($urandom_range(3) == 0) ? $urandom : $signed($urandom_range(2000)) - 1000;
            push_add(lo, hi, d);
        end
    endtask

    initial begin
        int unsigned sizes[8];
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_range_lo = '0;
        i_range_hi = '0;
        i_delta = '0;
        leaf_cnt = LEAVES;
        foreach (span_max[k]) begin
            span_max[k] = '0;
            span_tag[k] = '0;
        end
        sizes = '{1, 2, 1024, 7, 100, 3, 513, 1024};

        // directed beats at the reset count
        push_add(1, 1024, 32'sh7fffffff);
        push_add(1, 1024, 32'sh7fffffff);
        push_add(1024, 1024, 32'sh80000000);
        push_add(1, 1, -5);
        push_add(512, 513, 9);
        push_add(0, 10, 4);           // low below one
        push_add(20, 10, 4);          // empty range
        push_add(1, 1025, 4);         // past the count
        push_add(2047, 2047, -1);
        push_add(1, 1024, 32'sh80000000);
        push_add(1, 1024, 32'sh80000000);
        push_kind(K_DRAIN, 0);
        push_kind(K_CFG, 1);
        push_add(1, 1, 100);
        push_add(1, 2, 100);
        push_add(2, 2, 100);
        push_kind(K_CFG, 0);          // held as one
        push_add(1, 1, -1);
        push_kind(K_CFG, 2047);       // held at the maximum
        push_add(1, 1024, 1);
        push_add(300, 700, -3);
        push_kind(K_CFG, 1536);
        push_add(1000, 1024, 7);

        foreach (sizes[s]) begin
            push_kind(K_CFG, 11'(sizes[s]));
            push_random(135, sizes[s] > LEAVES ? LEAVES : sizes[s]);
            push_kind(K_DRAIN, 0);
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_q.size() == 0 && !start);
        wait (max_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (max_q.size() != 0) report($sformatf("%0d results never came", max_q.size()));

        $display("covered %0d adds (%0d with empty or outside ranges)", n_taken, n_bad_range);
        $display("%0d results checked, %0d count writes", n_seen, n_cfg);
        if (n_err == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("timed out with %0d results outstanding", max_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/ramst_pkg.sv
rtl/ramst_mem.sv
rtl/range_add_max_segment_tree.sv
dv/tb_range_add_max_segment_tree.sv
